// ----- rtl/core/ppbs_pkg.sv -----
package ppbs_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int SCORE_W     = 16;
    localparam int DEPTH_W     = 5;

    localparam logic [1:0] OP_RET  = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef enum logic [1:0] {
        PH_PRE,
        PH_PUSH,
        PH_POP,
        PH_OFF
    } phase_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] operand;
    } in_word_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0] best_depth;
        logic               function_counted;
    } out_word_t;

    typedef struct packed {
        logic               valid;
        logic               is_ret;
        logic               is_pop;
        logic               qualify;
        logic [CNT_W-1:0]   pair_depth;
        logic [7:0]         operand;
    } trk_word_t;

endpackage

// ----- rtl/core/ppbs_stack_ram.sv -----
module ppbs_stack_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ppbs_pkg::ADDR_W-1:0] waddr,
    input  logic [7:0]                 wdata,
    input  logic                       re,
    input  logic [ppbs_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                 rdata
);
    import ppbs_pkg::*;

    logic [7:0] mem [STACK_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/ppbs_track.sv -----
module ppbs_track (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        item_valid,
    input  ppbs_pkg::in_word_t          item,
    output ppbs_pkg::trk_word_t         stage,
    output logic                        mem_we,
    output logic [ppbs_pkg::ADDR_W-1:0] mem_waddr,
    output logic [7:0]                  mem_wdata,
    output logic                        mem_re,
    output logic [ppbs_pkg::ADDR_W-1:0] mem_raddr
);
    import ppbs_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pair_reg, pair_next;
    logic [CNT_W-1:0] count_dec;
    trk_word_t        stage_reg, stage_next;
    logic             accept;
    logic             push_ok;
    logic             pop_ok;

    assign accept    = advance && item_valid;
    assign count_dec = count_reg - 1'b1;
    assign push_ok   = (phase_reg == PH_PRE || phase_reg == PH_PUSH)
                       && (count_reg < CNT_W'(STACK_DEPTH));
    assign pop_ok    = (phase_reg == PH_PUSH || phase_reg == PH_POP)
                       && (count_reg != '0);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        pair_next  = pair_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = count_reg[ADDR_W-1:0];
        mem_raddr  = count_dec[ADDR_W-1:0];
        mem_wdata  = item.operand;

        stage_next            = stage_reg;
        stage_next.valid      = accept;
        if (accept)
        begin
            stage_next.is_ret     = 1'b0;
            stage_next.is_pop     = 1'b0;
            stage_next.qualify    = 1'b0;
            stage_next.pair_depth = pair_reg;
            stage_next.operand    = item.operand;
            case (item.op)
                OP_RET:
                begin
                    stage_next.is_ret  = 1'b1;
                    stage_next.qualify = (phase_reg == PH_POP) && (pair_reg > CNT_W'(1))
                                         && (count_reg == '0);
                    phase_next = PH_PRE;
                    count_next = '0;
                    pair_next  = '0;
                end
                OP_PUSH:
                begin
                    if (push_ok)
                    begin
                        phase_next = PH_PUSH;
                        count_next = count_reg + 1'b1;
                        mem_we     = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_OFF;
                    end
                end
                OP_POP:
                begin
                    if (pop_ok)
                    begin
                        phase_next        = PH_POP;
                        count_next        = count_dec;
                        pair_next         = pair_reg + 1'b1;
                        mem_re            = 1'b1;
                        stage_next.is_pop = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_OFF;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (!advance)
        begin
            stage_next = stage_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PRE;
            count_reg <= '0;
            pair_reg  <= '0;
            stage_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            pair_reg  <= pair_next;
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

// ----- rtl/core/ppbs_score.sv -----
module ppbs_score (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  ppbs_pkg::trk_word_t stage,
    input  logic [7:0]          rdata,
    output logic                result_valid,
    output ppbs_pkg::out_word_t result
);
    import ppbs_pkg::*;

    logic [SCORE_W-1:0] count_reg, count_next;
    logic [DEPTH_W-1:0] best_reg, best_next;
    logic               off_reg, off_next;
    logic               valid_reg;
    out_word_t          result_reg, result_next;
    logic               counted;
    logic               take;

    assign take = advance && stage.valid;

    always_comb
    begin
        count_next = count_reg;
        best_next  = best_reg;
        off_next   = off_reg;
        counted    = 1'b0;
        if (take)
        begin
            if (stage.is_ret)
            begin
                counted  = stage.qualify && !off_reg;
                off_next = 1'b0;
                if (counted)
                begin
                    if (count_reg != SCORE_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (DEPTH_W'(stage.pair_depth) > best_reg)
                    begin
                        best_next = DEPTH_W'(stage.pair_depth);
                    end
                end
            end
            else if (stage.is_pop && (rdata != stage.operand))
            begin
                off_next = 1'b1;
            end
        end
        result_next.score            = (count_next == SCORE_W'(1)) ? '0 : count_next;
        result_next.best_depth       = best_next;
        result_next.function_counted = counted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            best_reg  <= '0;
            off_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            best_reg  <= best_next;
            off_reg   <= off_next;
            if (advance)
            begin
                valid_reg <= stage.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/core/push_pop_balance_scorer_top.sv -----
// Scores a stream of classified 8051 instructions (return, push, pop) for
// balanced register saving and returns one result word per input word: the
// running count of qualifying functions (shown as zero while it is one), the
// best matched depth and a flag for the return that closed a qualifying
// function. Each word passes a two-stage pipeline (stack tracking with the
// RAM access, then compare and scoring into the output register), and one
// word is taken every cycle while the output is drained. The pushed operands
// sit in a 16-entry synchronous RAM; a pop reads its entry at acceptance and
// the scoring stage compares it with the popped operand. A stall on the
// result side holds the whole pipeline and stalls the input.
module push_pop_balance_scorer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  ppbs_pkg::in_word_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output ppbs_pkg::out_word_t result
);
    import ppbs_pkg::*;

    trk_word_t         stage;
    logic              advance;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;

    assign advance    = !result_valid || !result_stall;
    assign item_stall = !advance;

    ppbs_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item),
        .stage      (stage),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr)
    );

    ppbs_stack_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ppbs_score u_score (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .stage        (stage),
        .rdata        (mem_rdata),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
